[rtl/core/top4_bone_influence_table_core_assert.svh]
// Assertion macros for the bone influence table core.
`ifndef TOP4_BONE_INFLUENCE_TABLE_CORE_ASSERT_SVH
`define TOP4_BONE_INFLUENCE_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/bit_pkg.sv]
// Shared types and constants for the bone influence table.
`default_nettype none
package bit_pkg;
    localparam int POINTS    = 4096;
    localparam int SLOTS     = 4;
    localparam int BONE_BITS = 8;
    localparam int PW        = $clog2(POINTS);
    localparam int WW        = 16;
    localparam int SW        = WW + 2;
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic          req_type;
        logic [11:0]   point_index;
        logic [7:0]    bone_index;
        logic [WW-1:0] weight;
    } t_req;

    typedef struct packed {
        logic [3:0][7:0]    bone;
        logic [3:0][WW-1:0] share;
        logic               sum_was_zero;
    } t_rsp;
endpackage
`default_nettype wire

[rtl/core/bit_front.sv]
// Front end: two-entry request queue between the input port and the back end.
`default_nettype none
module bit_front import bit_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    output logic      o_full,
    output logic      o_valid,
    output t_req      o_req,
    input  wire logic i_take
);
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_req   = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_req;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `include "top4_bone_influence_table_core_assert.svh"
    `BIT_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `BIT_ASSERT_NXT(a_full_hold, i_clk, i_rst_n, o_full && !w_pop, o_full)
    `BIT_ASSERT_IMP(a_ptr_eq, i_clk, i_rst_n, r_cnt == 2'd0 || r_cnt == 2'd2, r_wp == r_rp)
endmodule
`default_nettype wire

[rtl/core/bit_back.sv]
// Back end: table memory, clear sweep, add update and serial share divider.
`default_nettype none
module bit_back import bit_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_req i_req,
    output logic      o_take,
    output logic      o_valid,
    output t_rsp      o_rsp,
    input  wire logic i_pop
);
    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EXE, S_DIV, S_OUT} t_st;
    typedef struct packed {
        logic [3:0][BONE_BITS-1:0] bone;
        logic [3:0][WW-1:0]        wt;
        logic [1:0]                ls;
        logic [WW-1:0]             lw;
    } t_ent;

    t_ent          r_mem [POINTS];
    t_st           r_st;
    logic [PW:0]   r_clr;
    t_req          r_req;
    t_ent          r_ent;
    logic [1:0]    r_k;
    logic [4:0]    r_bit;
    logic [SW-1:0] r_rem;
    logic [WW-1:0] r_q;
    logic [SW-1:0] r_sum;
    t_rsp          r_wrk;
    t_rsp          r_rsp;
    logic          r_ovalid;
    logic          r_we;
    logic [PW-1:0] r_wa;
    t_ent          r_wd;

    t_ent          n_ent;
    logic [SW-1:0] w_sum;
    logic [SW:0]   w_trial;
    logic [WW+14:0] w_num;
    logic [1:0]    w_ls;
    logic [WW-1:0] w_lw;
    logic          w_inrange;

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;
    assign o_take  = r_st == S_IDLE;
    assign w_inrange = 32'(r_req.point_index) < POINTS;

    always_comb begin
        n_ent = r_ent;
        n_ent.wt[r_ent.ls]   = r_req.weight;
        n_ent.bone[r_ent.ls] = r_req.bone_index[BONE_BITS-1:0];
        w_ls = 2'd0;
        w_lw = n_ent.wt[0];
        for (int s = 1; s < SLOTS; s++) begin
            if (n_ent.wt[s] < w_lw) begin
                w_ls = 2'(s);
                w_lw = n_ent.wt[s];
            end
        end
        n_ent.ls = w_ls;
        n_ent.lw = w_lw;
        w_sum = SW'(r_ent.wt[0]) + SW'(r_ent.wt[1]) + SW'(r_ent.wt[2]) + SW'(r_ent.wt[3]);
        w_num = {r_ent.wt[r_k], 15'd0};
        w_trial = {r_rem, w_num[r_bit]};
    end

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_wa] <= r_wd;
        if (r_st == S_RD) r_ent <= r_mem[r_req.point_index[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_ovalid <= 1'b0; r_we <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (r_ovalid && i_pop) r_ovalid <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_we <= 1'b1;
                    r_wa <= r_clr[PW-1:0];
                    r_wd <= '0;
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (PW+1)'(POINTS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_req <= i_req;
                    r_st  <= S_RD;
                end
                S_RD: r_st <= S_EXE;
                S_EXE: begin
                    if (r_req.req_type == REQ_ADD) begin
                        if (w_inrange && r_req.weight > r_ent.lw) begin
                            r_we <= 1'b1;
                            r_wa <= r_req.point_index[PW-1:0];
                            r_wd <= n_ent;
                        end
                        r_st <= S_IDLE;
                    end else begin
                        for (int s = 0; s < 4; s++)
                            r_wrk.bone[s] <= w_inrange ? 8'(r_ent.bone[s]) : 8'd0;
                        r_wrk.share <= '0;
                        r_wrk.sum_was_zero <= !w_inrange || w_sum == '0;
                        r_sum <= w_sum;
                        r_k <= 2'd0; r_bit <= 5'(WW + 14); r_rem <= '0;
                        r_st <= (!w_inrange || w_sum == '0) ? S_OUT : S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (w_trial >= {1'b0, r_sum}) begin
                        r_rem <= SW'(w_trial - {1'b0, r_sum});
                        r_q <= {r_q[WW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[SW-1:0];
                        r_q <= {r_q[WW-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 5'd0) begin
                        r_wrk.share[r_k] <= (w_trial >= {1'b0, r_sum})
                                            ? {r_q[WW-2:0], 1'b1}
                                            : {r_q[WW-2:0], 1'b0};
                        r_rem <= '0; r_bit <= 5'(WW + 14);
                        r_k <= r_k + 1'b1;
                        if (r_k == 2'd3) r_st <= S_OUT;
                    end
                end
                S_OUT: if (!r_ovalid || i_pop) begin
                    r_rsp <= r_wrk;
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `include "top4_bone_influence_table_core_assert.svh"
    `BIT_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_take, r_st == S_IDLE)
    `BIT_ASSERT_IMP(a_no_wr_div, i_clk, i_rst_n, r_st == S_DIV, !r_we)
    `BIT_ASSERT_NXT(a_out_set, i_clk, i_rst_n, r_st == S_OUT && (!r_ovalid || i_pop), r_ovalid)
endmodule
`default_nettype wire

[rtl/core/top4_bone_influence_table_core.sv]
// Top level of the top-four bone influence table.
//   channel | direction | handshake   | payload
//   request | in        | push / full | req_type, point_index, bone_index, weight
//   result  | out       | pop / empty | bone_a..d, share_a..d, sum_was_zero
// An add holds the back end through take, memory read and update; the write
// back overlaps the next take.
// A read holds it through take, memory read, division and output: the shared
// one-bit-per-cycle divider produces the four shares in turn; a zero-sum read skips it.
// After reset a sweep clears all 4096 table entries; full stays high meanwhile
// once the two-entry request queue fills. Reset is synchronous, active low.
// A waiting result holds the back end only if a second read finishes first.
`default_nettype none
module top4_bone_influence_table_core import bit_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_req_type,
    input  wire logic [11:0] i_point_index,
    input  wire logic [7:0]  i_bone_index,
    input  wire logic [15:0] i_weight,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_bone_a,
    output logic [7:0]       o_bone_b,
    output logic [7:0]       o_bone_c,
    output logic [7:0]       o_bone_d,
    output logic [15:0]      o_share_a,
    output logic [15:0]      o_share_b,
    output logic [15:0]      o_share_c,
    output logic [15:0]      o_share_d,
    output logic             o_sum_was_zero
);
    t_req w_in, w_q;
    t_rsp w_rsp;
    logic w_qv, w_take, w_ov;

    assign w_in = '{req_type: i_req_type, point_index: i_point_index,
                    bone_index: i_bone_index, weight: i_weight};

    bit_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_req(w_in),
        .o_full(full), .o_valid(w_qv), .o_req(w_q), .i_take(w_take)
    );

    bit_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .i_req(w_q),
        .o_take(w_take), .o_valid(w_ov), .o_rsp(w_rsp), .i_pop(pop)
    );

    assign empty          = !w_ov;
    assign o_bone_a       = w_rsp.bone[0];
    assign o_bone_b       = w_rsp.bone[1];
    assign o_bone_c       = w_rsp.bone[2];
    assign o_bone_d       = w_rsp.bone[3];
    assign o_share_a      = w_rsp.share[0];
    assign o_share_b      = w_rsp.share[1];
    assign o_share_c      = w_rsp.share[2];
    assign o_share_d      = w_rsp.share[3];
    assign o_sum_was_zero = w_rsp.sum_was_zero;
endmodule
`default_nettype wire
